>>> rtl/core/etp_pkg.sv
// etp_pkg: types and constants shared by the annotation region tagger
// no dependencies; imported by etp_step, edf_tal_annotation_parser_unit and the testbench

package etp_pkg;

  localparam logic [7:0] BYTE_SEP   = 8'd20;
  localparam logic [7:0] BYTE_DUR   = 8'd21;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ONSET = 3'd1,
    MODE_DUR   = 3'd2,
    MODE_TEXT  = 3'd3
  } etp_mode_t;

  typedef enum logic [2:0] {
    KIND_PAD   = 3'd0,
    KIND_ONSET = 3'd1,
    KIND_DUR   = 3'd2,
    KIND_TEXT  = 3'd3,
    KIND_DELIM = 3'd4
  } etp_kind_t;

  typedef struct packed {
    etp_mode_t mode;
    logic      dot_seen;
    logic      nonempty;
    logic      last_dot;
    logic      bad;
    logic      pending;
    logic      text_seen;
  } etp_state_t;

  localparam etp_state_t ST_RESET = '{
    mode: MODE_IDLE, dot_seen: 1'b0, nonempty: 1'b0, last_dot: 1'b0,
    bad: 1'b0, pending: 1'b0, text_seen: 1'b0
  };

  typedef struct packed {
    logic [7:0] byte_echo;
    etp_kind_t  kind;
    logic       field_end;
    logic       field_ok;
    logic       tal_end;
    logic       tal_has_text;
    logic       region_end;
  } etp_res_t;

endpackage

>>> rtl/core/etp_step.sv
// etp_step: per-byte tag decision and parser state update, purely combinational
// depends on etp_pkg

module etp_step (
  input  etp_pkg::etp_state_t state_i,
  input  logic [7:0]          tal_byte,
  input  logic                region_last,
  output etp_pkg::etp_state_t state_nxt,
  output etp_pkg::etp_res_t   res
);
  import etp_pkg::*;

  etp_state_t st;
  logic       is_digit;
  logic       is_sign;

  assign is_digit = (tal_byte >= CHAR_ZERO) && (tal_byte <= CHAR_NINE);
  assign is_sign  = (tal_byte == CHAR_PLUS) || (tal_byte == CHAR_MINUS);

  // number character update shared by onset and duration
  function automatic etp_state_t num_char(etp_state_t s, logic [7:0] b, logic dig);
    etp_state_t o;
    o = s;
    o.nonempty = 1'b1;
    if (b == CHAR_DOT && !s.dot_seen) begin
      o.dot_seen = 1'b1;
      o.last_dot = 1'b1;
    end else if (dig) begin
      o.last_dot = 1'b0;
    end else begin
      o.bad = 1'b1;
    end
    return o;
  endfunction

  function automatic etp_state_t clr_field(etp_state_t s);
    etp_state_t o;
    o = s;
    o.dot_seen = 1'b0;
    o.nonempty = 1'b0;
    o.last_dot = 1'b0;
    o.bad      = 1'b0;
    return o;
  endfunction

  always_comb begin
    st               = state_i;
    res.byte_echo    = tal_byte;
    res.kind         = KIND_PAD;
    res.field_end    = 1'b0;
    res.field_ok     = 1'b0;
    res.tal_end      = 1'b0;
    res.tal_has_text = 1'b0;
    res.region_end   = region_last;
    unique case (state_i.mode)
      MODE_DUR: begin
        if (tal_byte == BYTE_SEP) begin
          res.kind      = KIND_DELIM;
          res.field_end = 1'b1;
          res.field_ok  = !state_i.bad;
          st            = clr_field(state_i);
          st.mode       = MODE_TEXT;
          st.pending    = 1'b1;
        end else begin
          res.kind = KIND_DUR;
          st       = num_char(state_i, tal_byte, is_digit);
        end
      end
      MODE_TEXT: begin
        if (state_i.pending && tal_byte == 8'd0) begin
          res.kind         = KIND_DELIM;
          res.tal_end      = 1'b1;
          res.tal_has_text = state_i.text_seen;
          st               = ST_RESET;
        end else if (tal_byte == BYTE_SEP) begin
          res.kind      = KIND_DELIM;
          res.field_end = 1'b1;
          res.field_ok  = 1'b1;
          st            = clr_field(state_i);
          st.text_seen  = state_i.text_seen | state_i.nonempty;
          st.pending    = 1'b1;
        end else begin
          res.kind    = KIND_TEXT;
          st.nonempty = 1'b1;
          st.pending  = 1'b0;
        end
      end
      default: begin
        // idle and onset share the delimiter handling
        if (tal_byte == BYTE_SEP || tal_byte == BYTE_DUR) begin
          res.kind      = KIND_DELIM;
          res.field_end = 1'b1;
          res.field_ok  = (state_i.mode == MODE_ONSET) && state_i.nonempty &&
                          !state_i.bad && !state_i.last_dot;
          st            = clr_field(state_i);
          st.mode       = (tal_byte == BYTE_DUR) ? MODE_DUR : MODE_TEXT;
          st.pending    = (tal_byte == BYTE_SEP);
        end else if (state_i.mode != MODE_ONSET) begin
          if (tal_byte != 8'd0) begin
            res.kind    = KIND_ONSET;
            st          = clr_field(state_i);
            st.nonempty = 1'b1;
            st.bad      = !is_sign;
            st.mode     = MODE_ONSET;
          end
        end else begin
          res.kind = KIND_ONSET;
          st       = num_char(state_i, tal_byte, is_digit);
        end
      end
    endcase
    state_nxt = region_last ? ST_RESET : st;
  end

endmodule

>>> rtl/core/edf_tal_annotation_parser_unit.sv
// edf_tal_annotation_parser_unit: byte tagger for an annotation region
// path from input acceptance to result valid: input register, then result register
// throughput one byte per cycle while out_ready holds; the parser state register closes the only loop
// rst_n synchronous active low: clears both stage valids and the parser state
// depends on etp_pkg and etp_step

module edf_tal_annotation_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_tal_byte,
  input  logic       in_region_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_echo,
  output logic [2:0] out_field_kind,
  output logic       out_field_end,
  output logic       out_field_ok,
  output logic       out_tal_end,
  output logic       out_tal_has_text,
  output logic       out_region_end
);
  import etp_pkg::*;

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       out_vld_r;
  etp_state_t state_r;
  etp_state_t state_nxt;
  etp_res_t   res_r;
  etp_res_t   res_nxt;
  logic       advance;

  // the held request moves on when the result register is free or being drained
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  etp_step u_step (
    .state_i     (state_r),
    .tal_byte    (byte_r),
    .region_last (last_r),
    .state_nxt   (state_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= ST_RESET;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_tal_byte;
      last_r <= in_region_last;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte_echo    = res_r.byte_echo;
  assign out_field_kind   = res_r.kind;
  assign out_field_end    = res_r.field_end;
  assign out_field_ok     = res_r.field_ok;
  assign out_tal_end      = res_r.tal_end;
  assign out_tal_has_text = res_r.tal_has_text;
  assign out_region_end   = res_r.region_end;

  a_ok_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.field_ok |-> res_r.field_end)
    else $error("field_ok without field_end");

  a_end_is_delim: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.tal_end || res_r.field_end) |-> res_r.kind == KIND_DELIM)
    else $error("field or tal end on a non-delimiter byte");

  a_end_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.tal_end && res_r.field_end))
    else $error("tal end and field end together");

  a_region_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_r |=> state_r == ST_RESET)
    else $error("parser state not cleared after region end");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(res_r))
    else $error("result changed while stalled");

endmodule

>>> test/testbench.sv
// testbench for edf_tal_annotation_parser_unit: byte tagging of an annotation region
// checks results: typed tags or in-file predictor; directed rows, then random TALs
// depends on etp_pkg and the unit itself

module testbench;
  import etp_pkg::*;

  localparam int unsigned TOTAL_BYTES = 1050;
  localparam int unsigned CALM_TAIL   = 150;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef struct packed {
    etp_mode_t mode;
    logic      dot_seen;
    logic      nonempty;
    logic      trail_dot;
    logic      bad;
    logic      after_sep;
    logic      text_seen;
  } tag_state_t;

  localparam tag_state_t TAG_CLEAR = '{MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } region_byte_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         typed;
    etp_kind_t  kind;
    logic       fend;
    logic       fok;
    logic       tend;
    logic       thas;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_tal_byte = 8'h00;
  logic       in_region_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_echo;
  logic [2:0] out_field_kind;
  logic       out_field_end;
  logic       out_field_ok;
  logic       out_tal_end;
  logic       out_tal_has_text;
  logic       out_region_end;

  tag_state_t   tag_st = TAG_CLEAR;
  etp_res_t     expected_tags[$];
  region_byte_t feed_q[$];

  int unsigned sent_bytes = 0;
  int unsigned tagged_bytes = 0;
  int unsigned tal_ends = 0;
  int unsigned region_ends = 0;
  int unsigned failed_checks = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_pct = 30;
  int unsigned stall_pct = 30;
  int unsigned stall_left = 0;

  // directed rows; typed ones carry the expected tag, the rest go to the predictor
  dir_row_t dir_tab [27] = '{
    '{8'h00, 1'b0, 1'b1, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // padding after reset
    '{8'h14, 1'b0, 1'b1, KIND_DELIM, 1'b1, 1'b0, 1'b0, 1'b0}, // empty onset by 20
    '{8'h00, 1'b0, 1'b1, KIND_DELIM, 1'b0, 1'b0, 1'b1, 1'b0}, // tal end, no text
    '{8'h15, 1'b0, 1'b1, KIND_DELIM, 1'b1, 1'b0, 1'b0, 1'b0}, // empty onset by 21
    '{8'h14, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // empty duration
    '{8'h00, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h2B, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // sign only onset
    '{8'h15, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h39, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h2E, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h30, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h15, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // 21 inside a duration
    '{8'h14, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h41, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // zero inside text
    '{8'h14, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h14, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // empty text
    '{8'h00, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // tal end with text
    '{8'hFF, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // onset without sign
    '{8'h2E, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h2E, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // second dot
    '{8'h14, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // onset straight to text
    '{8'h80, 1'b1, 1'b1, KIND_TEXT,  1'b0, 1'b0, 1'b0, 1'b0}, // region ends mid text
    '{8'h2D, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h31, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h2E, 1'b0, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}, // trailing dot
    '{8'h14, 1'b1, 1'b0, KIND_PAD,   1'b0, 1'b0, 1'b0, 1'b0}
  };

  edf_tal_annotation_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tal_byte      (in_tal_byte),
    .in_region_last   (in_region_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_echo    (out_byte_echo),
    .out_field_kind   (out_field_kind),
    .out_field_end    (out_field_end),
    .out_field_ok     (out_field_ok),
    .out_tal_end      (out_tal_end),
    .out_tal_has_text (out_tal_has_text),
    .out_region_end   (out_region_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- tag predictor

  function automatic void clear_number();
    tag_st.dot_seen  = 1'b0;
    tag_st.nonempty  = 1'b0;
    tag_st.trail_dot = 1'b0;
    tag_st.bad       = 1'b0;
  endfunction

  function automatic void number_byte(input logic [7:0] b);
    tag_st.nonempty = 1'b1;
    if (b == CHAR_DOT && !tag_st.dot_seen) begin
      tag_st.dot_seen  = 1'b1;
      tag_st.trail_dot = 1'b1;
    end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      tag_st.trail_dot = 1'b0;
    end else begin
      tag_st.bad = 1'b1;
    end
  endfunction

  function automatic etp_res_t tag_next(input logic [7:0] b, input logic last);
    etp_res_t r;
    r = '0;
    r.byte_echo  = b;
    r.region_end = last;
    r.kind       = KIND_PAD;
    case (tag_st.mode)
      MODE_DUR: begin
        if (b == BYTE_SEP) begin
          r.kind      = KIND_DELIM;
          r.field_end = 1'b1;
          r.field_ok  = !tag_st.bad;
          clear_number();
          tag_st.mode      = MODE_TEXT;
          tag_st.after_sep = 1'b1;
        end else begin
          r.kind = KIND_DUR;
          number_byte(b);
        end
      end
      MODE_TEXT: begin
        if (tag_st.after_sep && b == 8'h00) begin
          r.kind         = KIND_DELIM;
          r.tal_end      = 1'b1;
          r.tal_has_text = tag_st.text_seen;
          tag_st         = TAG_CLEAR;
        end else if (b == BYTE_SEP) begin
          r.kind      = KIND_DELIM;
          r.field_end = 1'b1;
          r.field_ok  = 1'b1;
          if (tag_st.nonempty) tag_st.text_seen = 1'b1;
          clear_number();
          tag_st.after_sep = 1'b1;
        end else begin
          r.kind           = KIND_TEXT;
          tag_st.nonempty  = 1'b1;
          tag_st.after_sep = 1'b0;
        end
      end
      default: begin
        // expecting an onset, or inside one
        if (b == BYTE_SEP || b == BYTE_DUR) begin
          r.kind      = KIND_DELIM;
          r.field_end = 1'b1;
          r.field_ok  = tag_st.mode == MODE_ONSET && tag_st.nonempty && !tag_st.bad &&
                        !tag_st.trail_dot;
          clear_number();
          tag_st.mode      = (b == BYTE_DUR) ? MODE_DUR : MODE_TEXT;
          tag_st.after_sep = (b == BYTE_SEP);
        end else if (tag_st.mode == MODE_IDLE) begin
          if (b != 8'h00) begin
            r.kind = KIND_ONSET;
            clear_number();
            tag_st.nonempty = 1'b1;
            tag_st.bad      = !(b == CHAR_PLUS || b == CHAR_MINUS);
            tag_st.mode     = MODE_ONSET;
          end
        end else begin
          r.kind = KIND_ONSET;
          number_byte(b);
        end
      end
    endcase
    if (last) tag_st = TAG_CLEAR;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus building

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return BYTE_SEP;
      1: return BYTE_DUR;
      2: return 8'h00;
      3: return CHAR_DOT;
      4: return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
      5: return CHAR_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // appends one region byte to the stimulus queue
  task automatic queue_byte(input logic [7:0] b, input logic last);
    region_byte_t rb;
    rb.b    = b;
    rb.last = last;
    feed_q.insert(feed_q.size(), rb);
  endtask

  task automatic add_number(input bit onset);
    int         n;
    int         dot_at;
    int         spoil;
    logic [7:0] c;
    n      = $urandom_range(0, 6);
    dot_at = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, n);
    spoil  = $urandom_range(0, 9);
    // an onset with the sign left off may end up empty
    if (onset && spoil != 3)
      queue_byte($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS, 1'b0);
    for (int i = 0; i < n; i++) begin
      if (i == dot_at) queue_byte(CHAR_DOT, 1'b0);
      queue_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
    case (spoil)
      0: begin
        c = noise_byte();
        if (c == BYTE_SEP || c == BYTE_DUR) c = 8'hFF;
        queue_byte(c, 1'b0);
      end
      1: begin
        queue_byte(CHAR_DOT, 1'b0);
        queue_byte(CHAR_DOT, 1'b0);
      end
      2: queue_byte(CHAR_DOT, 1'b0);
      default: ;
    endcase
  endtask

  task automatic add_tal();
    int         len;
    logic [7:0] c;
    add_number(1'b1);
    if ($urandom_range(0, 1)) begin
      queue_byte(BYTE_DUR, 1'b0);
      add_number(1'b0);
    end
    queue_byte(BYTE_SEP, 1'b0);
    repeat ($urandom_range(0, 3)) begin
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        c = ($urandom_range(0, 7) == 0) ? BYTE_DUR : 8'($urandom_range(0, 255));
        if (c == BYTE_SEP) c = 8'h7E;
        // a zero straight after the separator would end the tal
        if (i == 0 && c == 8'h00) c = 8'h61;
        queue_byte(c, 1'b0);
      end
      queue_byte(BYTE_SEP, 1'b0);
    end
    queue_byte(8'h00, 1'b0);
    repeat ($urandom_range(0, 2)) queue_byte(8'h00, 1'b0);
    if ($urandom_range(0, 3) == 0) feed_q[feed_q.size() - 1].last = 1'b1;
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 8))
      queue_byte(noise_byte(), 1'($urandom_range(0, 9) == 0));
    // half the time resync the parser afterwards
    if ($urandom_range(0, 1)) feed_q[feed_q.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input etp_res_t typed_res);
    etp_res_t want;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_tal_byte    <= b;
    in_region_last <= last;
    do @(negedge clk); while (!in_ready);
    // request is taken at the coming edge
    want = tag_next(b, last);
    expected_tags.insert(expected_tags.size(), typed ? typed_res : want);
    @(posedge clk);
    sent_bytes++;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 9);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic log_fault(input string msg);
    fault_count++;
    $display("ERROR at %0t, result %0d: %s", $time, tagged_bytes, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) log_fault($sformatf("%s is %0d, should be %0d", name, got, want));
  endtask

  always @(negedge clk) begin : result_check
    etp_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tags.size() == 0) begin
        log_fault($sformatf("unexpected result, byte %02h", out_byte_echo));
      end else begin
        want = expected_tags.pop_front();
        compare_field("byte_echo", out_byte_echo, want.byte_echo);
        compare_field("field_kind", out_field_kind, int'(want.kind));
        compare_field("field_end", out_field_end, want.field_end);
        compare_field("field_ok", out_field_ok, want.field_ok);
        compare_field("tal_end", out_tal_end, want.tal_end);
        compare_field("tal_has_text", out_tal_has_text, want.tal_has_text);
        compare_field("region_end", out_region_end, want.region_end);
      end
      tagged_bytes++;
      if (out_tal_end) tal_ends++;
      if (out_region_end) region_ends++;
      if (out_field_end && !out_field_ok) failed_checks++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_tags.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- run

  initial begin : run
    etp_res_t     typed_res;
    region_byte_t nxt;
    bit           drained;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      typed_res = '{byte_echo: dir_tab[i].b, kind: dir_tab[i].kind,
                    field_end: dir_tab[i].fend, field_ok: dir_tab[i].fok,
                    tal_end: dir_tab[i].tend, tal_has_text: dir_tab[i].thas,
                    region_end: dir_tab[i].last};
      send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed, typed_res);
    end

    typed_res = '0;
    while (sent_bytes < TOTAL_BYTES) begin
      if (sent_bytes + CALM_TAIL >= TOTAL_BYTES) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (sent_bytes % 128 == 0) begin
        gap_pct   = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      // hold off once until the unit has drained
      if (!drained && sent_bytes >= TOTAL_BYTES / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge clk);
      end
      if (feed_q.size() == 0) begin
        if ($urandom_range(0, 7) == 0) add_noise();
        else add_tal();
      end
      nxt = feed_q.pop_front();
      send_byte(nxt.b, nxt.last, 1'b0, typed_res);
    end

    in_valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tagged %0d bytes: %0d TAL ends, %0d region ends, %0d failed field checks",
             tagged_bytes, tal_ends, region_ends, failed_checks);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
